@@ design/x86_subset_instruction_decoder_macros.svh @@
// Assertion macros shared by the decoder modules.
`ifndef X86_SUBSET_INSTRUCTION_DECODER_MACROS_SVH
`define X86_SUBSET_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XSID_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XSID_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/xsid_pkg.sv @@
// Types, codes and helper functions of the x86 subset decoder.
package xsid_pkg;

    localparam logic [3:0] MAX_WINDOW = 4'd12;
    localparam logic [3:0] COUNT_SAT  = 4'd15;

    typedef enum logic [5:0] {
        PH_DONE   = 6'b000001,
        PH_PREFIX = 6'b000010,
        PH_REX    = 6'b000100,
        PH_MODRM  = 6'b001000,
        PH_IMM    = 6'b010000,
        PH_ESC    = 6'b100000
    } phase_t;

    localparam logic [3:0] MN_POP     = 4'd0;
    localparam logic [3:0] MN_PUSH    = 4'd1;
    localparam logic [3:0] MN_RET     = 4'd2;
    localparam logic [3:0] MN_RETF    = 4'd3;
    localparam logic [3:0] MN_NOP     = 4'd4;
    localparam logic [3:0] MN_PUSHFQ  = 4'd5;
    localparam logic [3:0] MN_POPFQ   = 4'd6;
    localparam logic [3:0] MN_JMP     = 4'd7;
    localparam logic [3:0] MN_CALL    = 4'd8;
    localparam logic [3:0] MN_MOV     = 4'd9;
    localparam logic [3:0] MN_LEA     = 4'd10;
    localparam logic [3:0] MN_XOR     = 4'd11;
    localparam logic [3:0] MN_AND     = 4'd12;
    localparam logic [3:0] MN_OR      = 4'd13;
    localparam logic [3:0] MN_CMP     = 4'd14;
    localparam logic [3:0] MN_SYSCALL = 4'd15;

    localparam logic [2:0] FM_NONE    = 3'd0;
    localparam logic [2:0] FM_REG     = 3'd1;
    localparam logic [2:0] FM_REG_REG = 3'd2;
    localparam logic [2:0] FM_REG_IMM = 3'd3;
    localparam logic [2:0] FM_IMM     = 3'd4;
    localparam logic [2:0] FM_REG_MEM = 3'd5;

    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_RETF     = 8'hCB;
    localparam logic [7:0] OP_RET_IMM  = 8'hC2;
    localparam logic [7:0] OP_RETF_IMM = 8'hCA;
    localparam logic [7:0] OP_NOP      = 8'h90;
    localparam logic [7:0] OP_PUSHFQ   = 8'h9C;
    localparam logic [7:0] OP_POPFQ    = 8'h9D;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_MOV_ST   = 8'h89;
    localparam logic [7:0] OP_MOV_LD   = 8'h8B;
    localparam logic [7:0] OP_LEA      = 8'h8D;
    localparam logic [7:0] OP_XOR_ST   = 8'h31;
    localparam logic [7:0] OP_XOR_LD   = 8'h33;
    localparam logic [7:0] OP_AND      = 8'h21;
    localparam logic [7:0] OP_OR       = 8'h09;
    localparam logic [7:0] OP_CMP      = 8'h39;
    localparam logic [7:0] OP_ESC      = 8'h0F;
    localparam logic [7:0] OP_SYSCALL2 = 8'h05;

    // upper opcode bits of the register-embedded rows (58..5F, 50..57, B8..BF)
    localparam logic [4:0] OP_POP_ROW     = 5'b01011;
    localparam logic [4:0] OP_PUSH_ROW    = 5'b01010;
    localparam logic [4:0] OP_MOV_IMM_ROW = 5'b10111;
    localparam logic [3:0] REX_ROW        = 4'h4;

    localparam logic [2:0] GRP5_CALL = 3'd2;
    localparam logic [2:0] GRP5_JMP  = 3'd4;
    localparam logic [2:0] GRP5_PUSH = 3'd6;
    localparam logic [1:0] MOD_REG   = 2'b11;

    typedef struct packed {
        logic        decode_ok;
        logic [3:0]  instr_length;
        logic [3:0]  mnemonic;
        logic [2:0]  operand_form;
        logic [3:0]  first_reg;
        logic [3:0]  second_reg;
        logic [31:0] immediate;
        logic        is_return;
    } result_t;

    function automatic logic is_legacy(input logic [7:0] b);
        logic hit;
        case (b)
            8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E,
            8'h26, 8'h64, 8'h65, 8'h66, 8'h67: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_rex(input logic [7:0] b);
        return b[7:4] == REX_ROW;
    endfunction

endpackage

@@ design/xsid_if.sv @@
// Valid/ready channels for code bytes and decode results.
interface xsid_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       start_flag;
    logic       window_end;

    modport source (output valid, output byte_value, output start_flag,
                    output window_end, input ready);
    modport sink   (input valid, input byte_value, input start_flag,
                    input window_end, output ready);
endinterface

interface xsid_result_if;
    logic        valid;
    logic        ready;
    logic        decode_ok;
    logic [3:0]  instr_length;
    logic [3:0]  mnemonic;
    logic [2:0]  operand_form;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [31:0] immediate;
    logic        is_return;

    modport source (output valid, output decode_ok, output instr_length,
                    output mnemonic, output operand_form, output first_reg,
                    output second_reg, output immediate, output is_return,
                    input ready);
    modport sink   (input valid, input decode_ok, input instr_length,
                    input mnemonic, input operand_form, input first_reg,
                    input second_reg, input immediate, input is_return,
                    output ready);
endinterface

@@ design/xsid_step.sv @@
// Per-byte parser: decode state registers and next-state/result logic.
`include "x86_subset_instruction_decoder_macros.svh"

module xsid_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        byte_value,
    input  logic              start_flag,
    input  logic              window_end,
    output logic              res_valid,
    output xsid_pkg::result_t res
);

    xsid_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [7:0]  rex_reg, rex_next, rex_cur;
    logic [7:0]  opcode_reg, opcode_next, opcode_cur;
    logic [3:0]  count_reg, count_next, count_cur, count_new;
    logic [31:0] imm_reg, imm_next, imm_cur, imm_new;
    logic [1:0]  idx_reg, idx_next, idx_cur;
    logic [2:0]  idx_inc, needed;
    logic        last, wide;
    logic        do_emit, do_fail, do_more;
    xsid_pkg::phase_t more_ph;
    logic [3:0]  r_op, r_reg, r_rm;
    logic [3:0]  e_mn, e_r1, e_r2;
    logic [2:0]  e_form;
    logic [31:0] e_imm;
    logic        e_ret;

    always_comb
    begin
        phase_cur  = start_flag ? xsid_pkg::PH_PREFIX : phase_reg;
        rex_cur    = start_flag ? 8'd0 : rex_reg;
        opcode_cur = start_flag ? 8'd0 : opcode_reg;
        count_cur  = start_flag ? 4'd0 : count_reg;
        imm_cur    = start_flag ? 32'd0 : imm_reg;
        idx_cur    = start_flag ? 2'd0 : idx_reg;

        count_new = (count_cur < xsid_pkg::COUNT_SAT) ? count_cur + 4'd1 : count_cur;
        last      = window_end || (count_new >= xsid_pkg::MAX_WINDOW);

        r_op  = {rex_cur[0], byte_value[2:0]};
        r_reg = {rex_cur[2], byte_value[5:3]};
        r_rm  = {rex_cur[0], byte_value[2:0]};

        wide    = opcode_cur[7:3] == xsid_pkg::OP_MOV_IMM_ROW;
        needed  = wide ? 3'd4 : 3'd2;
        idx_inc = {1'b0, idx_cur} + 3'd1;
        imm_new = imm_cur | ({24'd0, byte_value} << {idx_cur, 3'b000});

        phase_next  = phase_cur;
        rex_next    = rex_cur;
        opcode_next = opcode_cur;
        count_next  = count_cur;
        imm_next    = imm_cur;
        idx_next    = idx_cur;

        do_emit = 1'b0;
        do_fail = 1'b0;
        do_more = 1'b0;
        more_ph = phase_cur;
        e_mn    = 4'd0;
        e_form  = xsid_pkg::FM_NONE;
        e_r1    = 4'd0;
        e_r2    = 4'd0;
        e_imm   = 32'd0;
        e_ret   = 1'b0;

        if (take && (phase_cur != xsid_pkg::PH_DONE))
        begin
            count_next = count_new;
            case (phase_cur)
                xsid_pkg::PH_PREFIX, xsid_pkg::PH_REX:
                begin
                    if ((phase_cur == xsid_pkg::PH_PREFIX) && xsid_pkg::is_legacy(byte_value))
                    begin
                        do_more = 1'b1;
                        more_ph = xsid_pkg::PH_PREFIX;
                    end
                    else if (xsid_pkg::is_rex(byte_value))
                    begin
                        rex_next = byte_value;
                        do_more  = 1'b1;
                        more_ph  = xsid_pkg::PH_REX;
                    end
                    else
                    begin
                        opcode_next = byte_value;
                        if (byte_value[7:3] == xsid_pkg::OP_POP_ROW)
                        begin
                            do_emit = 1'b1;
                            e_mn    = xsid_pkg::MN_POP;
                            e_form  = xsid_pkg::FM_REG;
                            e_r1    = r_op;
                        end
                        else if (byte_value[7:3] == xsid_pkg::OP_PUSH_ROW)
                        begin
                            do_emit = 1'b1;
                            e_mn    = xsid_pkg::MN_PUSH;
                            e_form  = xsid_pkg::FM_REG;
                            e_r1    = r_op;
                        end
                        else if (byte_value[7:3] == xsid_pkg::OP_MOV_IMM_ROW)
                        begin
                            do_more = 1'b1;
                            more_ph = xsid_pkg::PH_IMM;
                        end
                        else
                        begin
                            case (byte_value)
                                xsid_pkg::OP_RET:
                                begin
                                    do_emit = 1'b1;
                                    e_mn    = xsid_pkg::MN_RET;
                                    e_ret   = 1'b1;
                                end
                                xsid_pkg::OP_RETF:
                                begin
                                    do_emit = 1'b1;
                                    e_mn    = xsid_pkg::MN_RETF;
                                    e_ret   = 1'b1;
                                end
                                xsid_pkg::OP_NOP:
                                begin
                                    do_emit = 1'b1;
                                    e_mn    = xsid_pkg::MN_NOP;
                                end
                                xsid_pkg::OP_PUSHFQ:
                                begin
                                    do_emit = 1'b1;
                                    e_mn    = xsid_pkg::MN_PUSHFQ;
                                end
                                xsid_pkg::OP_POPFQ:
                                begin
                                    do_emit = 1'b1;
                                    e_mn    = xsid_pkg::MN_POPFQ;
                                end
                                xsid_pkg::OP_RET_IMM, xsid_pkg::OP_RETF_IMM:
                                begin
                                    do_more = 1'b1;
                                    more_ph = xsid_pkg::PH_IMM;
                                end
                                xsid_pkg::OP_GRP5, xsid_pkg::OP_MOV_ST,
                                xsid_pkg::OP_MOV_LD, xsid_pkg::OP_LEA,
                                xsid_pkg::OP_XOR_ST, xsid_pkg::OP_XOR_LD,
                                xsid_pkg::OP_AND, xsid_pkg::OP_OR,
                                xsid_pkg::OP_CMP:
                                begin
                                    do_more = 1'b1;
                                    more_ph = xsid_pkg::PH_MODRM;
                                end
                                xsid_pkg::OP_ESC:
                                begin
                                    do_more = 1'b1;
                                    more_ph = xsid_pkg::PH_ESC;
                                end
                                default: do_fail = 1'b1;
                            endcase
                        end
                    end
                end
                xsid_pkg::PH_MODRM:
                begin
                    if (byte_value[7:6] != xsid_pkg::MOD_REG)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                        e_form  = xsid_pkg::FM_REG_REG;
                        e_r1    = r_rm;
                        e_r2    = r_reg;
                        case (opcode_cur)
                            xsid_pkg::OP_GRP5:
                            begin
                                e_form = xsid_pkg::FM_REG;
                                e_r2   = 4'd0;
                                case (byte_value[5:3])
                                    xsid_pkg::GRP5_JMP:
                                    begin
                                        e_mn  = xsid_pkg::MN_JMP;
                                        e_ret = 1'b1;
                                    end
                                    xsid_pkg::GRP5_CALL: e_mn = xsid_pkg::MN_CALL;
                                    xsid_pkg::GRP5_PUSH: e_mn = xsid_pkg::MN_PUSH;
                                    default:
                                    begin
                                        do_emit = 1'b0;
                                        do_fail = 1'b1;
                                    end
                                endcase
                            end
                            xsid_pkg::OP_MOV_ST: e_mn = xsid_pkg::MN_MOV;
                            xsid_pkg::OP_MOV_LD:
                            begin
                                e_mn = xsid_pkg::MN_MOV;
                                e_r1 = r_reg;
                                e_r2 = r_rm;
                            end
                            xsid_pkg::OP_LEA:
                            begin
                                e_mn   = xsid_pkg::MN_LEA;
                                e_form = xsid_pkg::FM_REG_MEM;
                                e_r1   = r_reg;
                                e_r2   = r_rm;
                            end
                            xsid_pkg::OP_XOR_ST: e_mn = xsid_pkg::MN_XOR;
                            xsid_pkg::OP_XOR_LD:
                            begin
                                e_mn = xsid_pkg::MN_XOR;
                                e_r1 = r_reg;
                                e_r2 = r_rm;
                            end
                            xsid_pkg::OP_AND: e_mn = xsid_pkg::MN_AND;
                            xsid_pkg::OP_OR:  e_mn = xsid_pkg::MN_OR;
                            xsid_pkg::OP_CMP: e_mn = xsid_pkg::MN_CMP;
                            default:
                            begin
                                do_emit = 1'b0;
                                do_fail = 1'b1;
                            end
                        endcase
                    end
                end
                xsid_pkg::PH_IMM:
                begin
                    if (idx_inc < needed)
                    begin
                        imm_next = imm_new;
                        idx_next = idx_inc[1:0];
                        do_more  = 1'b1;
                        more_ph  = xsid_pkg::PH_IMM;
                    end
                    else if (wide)
                    begin
                        do_emit = 1'b1;
                        e_mn    = xsid_pkg::MN_MOV;
                        e_form  = xsid_pkg::FM_REG_IMM;
                        e_r1    = {rex_cur[0], opcode_cur[2:0]};
                        e_imm   = imm_new;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                        e_mn    = (opcode_cur == xsid_pkg::OP_RET_IMM) ?
                                  xsid_pkg::MN_RET : xsid_pkg::MN_RETF;
                        e_form  = xsid_pkg::FM_IMM;
                        e_imm   = {16'd0, imm_new[15:0]};
                        e_ret   = 1'b1;
                    end
                end
                xsid_pkg::PH_ESC:
                begin
                    if (byte_value == xsid_pkg::OP_SYSCALL2)
                    begin
                        do_emit = 1'b1;
                        e_mn    = xsid_pkg::MN_SYSCALL;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                default: do_fail = 1'b1;
            endcase

            if (do_more)
            begin
                if (last)
                    do_fail = 1'b1;
                else
                    phase_next = more_ph;
            end
            if (do_emit || do_fail)
                phase_next = xsid_pkg::PH_DONE;
        end

        res_valid = do_emit || do_fail;
        res       = '0;
        if (do_emit)
        begin
            res.decode_ok    = 1'b1;
            res.instr_length = count_new;
            res.mnemonic     = e_mn;
            res.operand_form = e_form;
            res.first_reg    = e_r1;
            res.second_reg   = e_r2;
            res.immediate    = e_imm;
            res.is_return    = e_ret;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= xsid_pkg::PH_PREFIX;
            rex_reg    <= 8'd0;
            opcode_reg <= 8'd0;
            count_reg  <= 4'd0;
            imm_reg    <= 32'd0;
            idx_reg    <= 2'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            rex_reg    <= rex_next;
            opcode_reg <= opcode_next;
            count_reg  <= count_next;
            imm_reg    <= imm_next;
            idx_reg    <= idx_next;
        end
    end

    `XSID_ASSERT_NEXT(a_result_ends_attempt, res_valid, phase_reg == xsid_pkg::PH_DONE, "result without attempt end")
    `XSID_ASSERT_NOW(a_done_is_quiet, take && !start_flag && phase_reg == xsid_pkg::PH_DONE, !res_valid, "result after attempt end")
    `XSID_ASSERT_NOW(a_fail_is_zero, res_valid && !res.decode_ok, res == '0, "failure result not cleared")

endmodule

@@ design/xsid_outbuf.sv @@
// Two-entry result buffer: output register plus skid register.
`include "x86_subset_instruction_decoder_macros.svh"

module xsid_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xsid_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output xsid_pkg::result_t out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    xsid_pkg::result_t main_data_reg, main_data_next;
    xsid_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    `XSID_ASSERT_NOW(a_skid_needs_main, skid_valid_reg, main_valid_reg, "skid entry without output entry")
    `XSID_ASSERT_NOW(a_no_overflow, push, !skid_valid_reg, "request pushed into full buffer")
    `XSID_ASSERT_NEXT(a_held_stays, main_valid_reg && !out_ready, main_valid_reg, "stalled result dropped")

endmodule

@@ design/x86_subset_instruction_decoder.sv @@
// Top level: byte-stream x86-64 subset decoder with valid/ready channels.
// One code byte is taken per request, one per clock when the result side keeps up;
// each decode attempt yields one registered result after the byte that decides it
// (recognized, unknown or truncated). Results pass through a two-entry output
// buffer, so code.ready stays high while one result waits and drops only when both
// entries are full; per-byte combinational parsing sets the one-byte-per-cycle rate.
module x86_subset_instruction_decoder (
    input  logic          clk,
    input  logic          rst_n,
    xsid_byte_if.sink     code,
    xsid_result_if.source result
);

    logic              take;
    logic              res_valid;
    logic              space;
    xsid_pkg::result_t res;
    xsid_pkg::result_t out_data;

    assign code.ready = space;
    assign take       = code.valid && space;

    xsid_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_value (code.byte_value),
        .start_flag (code.start_flag),
        .window_end (code.window_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    xsid_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.decode_ok    = out_data.decode_ok;
    assign result.instr_length = out_data.instr_length;
    assign result.mnemonic     = out_data.mnemonic;
    assign result.operand_form = out_data.operand_form;
    assign result.first_reg    = out_data.first_reg;
    assign result.second_reg   = out_data.second_reg;
    assign result.immediate    = out_data.immediate;
    assign result.is_return    = out_data.is_return;

endmodule
